// ===== sv/cbq_pkg.sv =====
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types and the fixed coefficient table of the cascaded biquad filter.
// ----------------------------------------------------------------------------
package cbq_pkg;

	localparam int CoefStages = 4;
	localparam int TapsPerStage = 3;
	localparam int MacTaps = 5;
	localparam int CoefW = 32;
	localparam int ValW = 40;
	localparam int OpndW = 21;

	typedef struct packed {
		logic issue;
		logic first;
		logic hi;
	} mac_req_t;

	// per stage: b0, b1, b2, -a1, -a2 in Q2.30
	function automatic logic signed [CoefW-1:0] coef_at(logic [1:0] stg, logic [2:0] tap);
		logic signed [CoefW-1:0] c;
		c = '0;
		case (stg)
			2'd0: begin
				case (tap)
					3'd0: c = 32'sd1071125;
					3'd1: c = 32'sd1071125;
					3'd2: c = 32'sd0;
					3'd3: c = 32'sd978078064;
					3'd4: c = 32'sd0;
					default: c = '0;
				endcase
			end
			2'd1: begin
				case (tap)
					3'd0: c = 32'sd1073741824;
					3'd1: c = -32'sd1678152825;
					3'd2: c = 32'sd1073741824;
					3'd3: c = 32'sd1973331733;
					3'd4: c = -32'sd936757797;
					default: c = '0;
				endcase
			end
			2'd2: begin
				case (tap)
					3'd0: c = 32'sd1073741824;
					3'd1: c = -32'sd1950226269;
					3'd2: c = 32'sd1073741824;
					3'd3: c = 32'sd2002199475;
					3'd4: c = -32'sd1009895658;
					default: c = '0;
				endcase
			end
			default: begin
				case (tap)
					3'd0: c = 32'sd1073741824;
					3'd1: c = -32'sd1995102310;
					3'd2: c = 32'sd1073741824;
					3'd3: c = 32'sd2026270286;
					3'd4: c = -32'sd1056897543;
					default: c = '0;
				endcase
			end
		endcase
		return c;
	endfunction

endpackage

// ===== sv/cascaded_biquad_iir.sv =====
// ----------------------------------------------------------------------------
// cascaded_biquad_iir
// Direct-form-I biquad cascade on 16-bit samples, Q24.16 stage values,
// one shared multiply-accumulate unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_stall, audio_in              | in
//  output   | out_valid, out_stall, audio_out           | out
//  config   | psel, penable, pwrite, paddr, pwdata,     | in/out
//           | prdata, pready (stage_count at 0x0)       |
//
//  a sample passes through the active stages in turn: each stage is
//  ten multiplies through the one shared multiplier plus drain and writeback
//  reset clears history to zero and stage_count to four
//  in_stall is high from the accepted beat until the result is registered
//  a finished result waits in the output register while the next beat enters
// ----------------------------------------------------------------------------
module cascaded_biquad_iir #(
	parameter int MAX_STAGES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [15:0] audio_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [15:0] audio_out
);
	import cbq_pkg::*;

	localparam int StageLim = (MAX_STAGES < CoefStages) ? MAX_STAGES : CoefStages;
	localparam int StgW = (StageLim > 1) ? $clog2(StageLim) : 1;

	localparam logic [2:0] TapX  = 3'd0;
	localparam logic [2:0] TapX1 = 3'd1;
	localparam logic [2:0] TapX2 = 3'd2;
	localparam logic [2:0] TapY1 = 3'd3;
	localparam logic [2:0] TapY2 = 3'd4;
	localparam logic [2:0] TapLast = 3'(MacTaps - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_WB,
		ST_FIN
	} state_t;

	state_t                   state_q;
	logic [2:0]               stage_count_q;
	logic [2:0]               n_eff;
	logic [StgW-1:0]          stg_q;
	logic [2:0]               tap_q;
	logic                     hi_q;
	logic signed [ValW-1:0]   cur_q;
	logic signed [ValW-1:0]   xh_q [StageLim][2];
	logic signed [ValW-1:0]   yh_q [StageLim][2];
	logic                     out_valid_q;
	logic signed [15:0]       audio_out_q;
	logic signed [ValW-1:0]   opnd_val;
	logic signed [OpndW-1:0]  opnd;
	logic signed [CoefW-1:0]  coef;
	logic signed [ValW-1:0]   mac_y;
	mac_req_t                 mac_req;
	logic                     last_stage;
	logic                     in_beat;
	logic                     cfg_wr;
	logic signed [23:0]       trunc;
	logic signed [15:0]       conv;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {29'd0, stage_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q <= 3'd4;
		end else if (cfg_wr) begin
			stage_count_q <= pwdata[2:0];
		end
	end

	assign n_eff = (stage_count_q > 3'(StageLim)) ? 3'(StageLim) : stage_count_q;
	assign last_stage = (3'(stg_q) + 3'd1) == n_eff;

	assign in_stall = (state_q != ST_IDLE);
	assign in_beat = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign audio_out = audio_out_q;

	// operand select for the shared unit
	always_comb begin
		case (tap_q)
			TapX:    opnd_val = cur_q;
			TapX1:   opnd_val = xh_q[stg_q][0];
			TapX2:   opnd_val = xh_q[stg_q][1];
			TapY1:   opnd_val = yh_q[stg_q][0];
			TapY2:   opnd_val = yh_q[stg_q][1];
			default: opnd_val = '0;
		endcase
	end

	assign opnd = hi_q ? {opnd_val[ValW-1], opnd_val[ValW-1:20]} : {1'b0, opnd_val[19:0]};
	assign coef = coef_at(2'(stg_q), tap_q);

	assign mac_req.issue = (state_q == ST_ISSUE);
	assign mac_req.first = (tap_q == TapX) && !hi_q;
	assign mac_req.hi = hi_q;

	cbq_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.coef   (coef),
		.opnd   (opnd),
		.y      (mac_y)
	);

	// truncate toward zero, then saturate to 16 bits
	assign trunc = cur_q[ValW-1:16] + 24'(cur_q[ValW-1] && (|cur_q[15:0]));
	assign conv = ((&trunc[23:15]) || !(|trunc[23:15])) ? trunc[15:0] :
		(trunc[23] ? 16'sh8000 : 16'sh7fff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stg_q <= '0;
			tap_q <= TapX;
			hi_q <= 1'b0;
			cur_q <= '0;
			out_valid_q <= 1'b0;
			audio_out_q <= '0;
			for (int s = 0; s < StageLim; s++) begin
				xh_q[s][0] <= '0;
				xh_q[s][1] <= '0;
				yh_q[s][0] <= '0;
				yh_q[s][1] <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						cur_q <= {{8{audio_in[15]}}, audio_in, 16'd0};
						stg_q <= '0;
						tap_q <= TapX;
						hi_q <= 1'b0;
						state_q <= (n_eff == 3'd0) ? ST_FIN : ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					hi_q <= !hi_q;
					if (hi_q) begin
						if (tap_q == TapLast) begin
							tap_q <= TapX;
							state_q <= ST_DRAIN;
						end else begin
							tap_q <= tap_q + 3'd1;
						end
					end
				end
				ST_DRAIN: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					xh_q[stg_q][1] <= xh_q[stg_q][0];
					xh_q[stg_q][0] <= cur_q;
					yh_q[stg_q][1] <= yh_q[stg_q][0];
					yh_q[stg_q][0] <= mac_y;
					cur_q <= mac_y;
					if (last_stage) begin
						state_q <= ST_FIN;
					end else begin
						stg_q <= stg_q + StgW'(1);
						state_q <= ST_ISSUE;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						audio_out_q <= conv;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> in_stall)
		else $error("input accepted twice in a row");

	a_wb_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |-> ($past(state_q) == ST_DRAIN))
		else $error("writeback without accumulator drain");

	a_stage_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> ((3'(stg_q) < n_eff) && (tap_q <= TapLast)))
		else $error("stage or tap index out of range");

endmodule

// ===== sv/cbq_mac.sv =====
// ----------------------------------------------------------------------------
// cbq_mac
// Shared multiply-accumulate unit: one 32x21 product per cycle, registered,
// then added into a wide exact accumulator; output is floor(acc / 2^30)
// saturated to 40 bits.
// ----------------------------------------------------------------------------
module cbq_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cbq_pkg::mac_req_t                   req,
	input  logic signed [cbq_pkg::CoefW-1:0]    coef,
	input  logic signed [cbq_pkg::OpndW-1:0]    opnd,
	output logic signed [cbq_pkg::ValW-1:0]     y
);
	import cbq_pkg::*;

	localparam int ProdW = CoefW + OpndW;
	localparam int AccW = 76;
	localparam int FracShift = 30;
	localparam int HiShift = 20;

	logic signed [ProdW-1:0] prod_s1;
	logic                    valid_s1;
	logic                    first_s1;
	logic                    hi_s1;
	logic signed [AccW-1:0]  acc_q;
	logic signed [AccW-1:0]  prod_ext;
	logic signed [AccW-1:0]  addend;
	logic signed [AccW-1:0]  shifted;
	logic                    in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
			hi_s1 <= 1'b0;
			prod_s1 <= '0;
		end else begin
			valid_s1 <= req.issue;
			if (req.issue) begin
				first_s1 <= req.first;
				hi_s1 <= req.hi;
				prod_s1 <= coef * opnd;
			end
		end
	end

	assign prod_ext = AccW'(prod_s1);
	assign addend = hi_s1 ? (prod_ext <<< HiShift) : prod_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			acc_q <= first_s1 ? addend : acc_q + addend;
		end
	end

	assign shifted = acc_q >>> FracShift;
	assign in_range = (&shifted[AccW-1:ValW-1]) || !(|shifted[AccW-1:ValW-1]);

	always_comb begin
		if (in_range) begin
			y = shifted[ValW-1:0];
		end else if (shifted[AccW-1]) begin
			y = {1'b1, {(ValW-1){1'b0}}};
		end else begin
			y = {1'b0, {(ValW-1){1'b1}}};
		end
	end

endmodule
